// ===== hw/rtl/tab_column_sample_select_macros.svh =====
// Assertion macros for the tab column sample select block.
// Used by the top level; no other dependencies.
`ifndef TAB_COLUMN_SAMPLE_SELECT_MACROS_SVH
`define TAB_COLUMN_SAMPLE_SELECT_MACROS_SVH

// same-cycle implication
`define TCSS_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcss assertion failed");

// next-cycle implication
`define TCSS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcss assertion failed");

`endif

// ===== hw/rtl/tcss_pkg.sv =====
// Shared types, constants and helpers for the tab column sample select block.
// No dependencies.
package tcss_pkg;

   localparam int BYTE_W      = 8;
   localparam int FILL_W      = 13;
   localparam int CNT_W       = 13;
   localparam int MAPCOL_W    = 12;
   localparam int FIXED_COLS  = 9;
   localparam int HDR_LEN     = 6;
   localparam int PREFIX_W    = 3;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = 2;
   localparam int FIFO_CNT_W  = 3;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
   localparam logic [BYTE_W-1:0] CH_NL   = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;

   typedef enum logic [1:0] {
      MODE_START,
      MODE_PREFIX,
      MODE_COMMENT,
      MODE_TABLE
   } line_mode_type;

   typedef enum logic {
      OP_TEXT = 1'b0,
      OP_MAP  = 1'b1
   } op_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [FILL_W-1:0] fill_before;
      logic              last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic         valid0;
      logic         valid1;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

   typedef struct packed {
      logic                  space2;
      logic [FIFO_CNT_W-1:0] count;
   } fifo_status_type;

   function automatic logic [BYTE_W-1:0] hdr_char(logic [PREFIX_W-1:0] pos);
      logic [BYTE_W-1:0] c;
      unique case (pos)
         3'd0:    c = CH_HASH;
         3'd1:    c = 8'h43;
         3'd2:    c = 8'h48;
         3'd3:    c = 8'h52;
         3'd4:    c = 8'h4F;
         3'd5:    c = 8'h4D;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic push_type push_add(push_type p, logic [BYTE_W-1:0] b,
                                         logic [FILL_W-1:0] f);
      push_type r;
      r = p;
      if (!p.valid0) begin
         r.valid0 = 1'b1;
         r.item0  = '{out_byte: b, fill_before: f, last_of_run: 1'b0};
      end else begin
         r.valid1 = 1'b1;
         r.item1  = '{out_byte: b, fill_before: f, last_of_run: 1'b0};
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/tcss_front.sv =====
// Front part: accepts items, holds the keep map and line state, classifies bytes.
// Pushes up to two results per item toward the queue. Depends on tcss_pkg.
module tcss_front import tcss_pkg::*; #(
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  op_type                in_op,
   input  logic [BYTE_W-1:0]     in_byte,
   input  logic [MAPCOL_W-1:0]   in_column,
   input  logic                  in_keep,
   input  fifo_status_type       fifo_stat,
   output push_type              push,
   output logic                  clearing
);

   localparam int AW = $clog2(MAX_COLUMNS);
   localparam int CW = $clog2(MAX_COLUMNS + 1);
   localparam logic [CW-1:0] COL_MAX   = CW'(MAX_COLUMNS);
   localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_COLUMNS - 1);

   logic keep_mem [MAX_COLUMNS];

   logic                clr_active_ff;
   logic [AW-1:0]       clr_addr_ff;
   logic                wr_valid_ff;
   logic [AW-1:0]       wr_addr_ff;
   logic                wr_keep_ff;
   logic                nxt_kept_ff;
   logic                old_kept_ff;
   logic [CNT_W-1:0]    kept_total_ff, kept_total_in;
   line_mode_type       mode_ff, mode_in;
   logic [PREFIX_W-1:0] pp_ff, pp_in;
   logic [CW-1:0]       column_ff, column_in;
   logic                tab_pend_ff, tab_pend_in;
   logic                ffp_ff, ffp_in;
   logic [CNT_W-1:0]    seen_ff, seen_in;
   logic                cur_kept_ff, cur_kept_in;

   logic                take, text_take, map_take, map_ok;
   logic [AW-1:0]       map_addr;
   logic [CW:0]         rd_col;
   logic                rd_ok;
   logic [AW-1:0]       rd_addr;
   logic                mem_we, mem_wd;
   logic [AW-1:0]       mem_wa;
   logic [CNT_W-1:0]    eff_total;
   logic [FILL_W-1:0]   fill;
   logic                table_path;
   push_type            p;

   assign clearing  = clr_active_ff;
   assign in_ready  = !clr_active_ff && fifo_stat.space2;
   assign take      = in_valid && in_ready;
   assign text_take = take && (in_op == OP_TEXT);
   assign map_ok    = (in_column >= MAPCOL_W'(FIXED_COLS))
                      && (32'(in_column) < 32'(MAX_COLUMNS));
   assign map_take  = take && (in_op == OP_MAP) && map_ok;
   assign map_addr  = AW'(in_column);

   assign rd_col  = {1'b0, column_in} + (CW+1)'(1);
   assign rd_ok   = rd_col < (CW+1)'(MAX_COLUMNS);
   assign rd_addr = AW'(rd_col);

   assign mem_we = clr_active_ff || wr_valid_ff;
   assign mem_wa = clr_active_ff ? clr_addr_ff : wr_addr_ff;
   assign mem_wd = clr_active_ff ? 1'b0 : wr_keep_ff;

   assign eff_total = kept_total_ff
                      + CNT_W'(wr_valid_ff && wr_keep_ff && !old_kept_ff)
                      - CNT_W'(wr_valid_ff && !wr_keep_ff && old_kept_ff);
   assign kept_total_in = eff_total;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         keep_mem[mem_wa] <= mem_wd;
      end
      if (clr_active_ff || !rd_ok) begin
         nxt_kept_ff <= 1'b0;
      end else if (map_take && map_addr == rd_addr) begin
         nxt_kept_ff <= in_keep;
      end else if (wr_valid_ff && wr_addr_ff == rd_addr) begin
         nxt_kept_ff <= wr_keep_ff;
      end else begin
         nxt_kept_ff <= keep_mem[rd_addr];
      end
      if (wr_valid_ff && wr_addr_ff == map_addr) begin
         old_kept_ff <= wr_keep_ff;
      end else begin
         old_kept_ff <= keep_mem[map_addr];
      end
      wr_addr_ff <= map_addr;
      wr_keep_ff <= in_keep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         wr_valid_ff   <= 1'b0;
         kept_total_ff <= '0;
      end else begin
         if (clr_active_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == ADDR_LAST) begin
               clr_active_ff <= 1'b0;
            end
         end
         wr_valid_ff   <= map_take;
         kept_total_ff <= kept_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_START;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_ff       <= '0;
         column_ff   <= '0;
         tab_pend_ff <= 1'b0;
         ffp_ff      <= 1'b0;
         seen_ff     <= '0;
         cur_kept_ff <= 1'b0;
      end else begin
         pp_ff       <= pp_in;
         column_ff   <= column_in;
         tab_pend_ff <= tab_pend_in;
         ffp_ff      <= ffp_in;
         seen_ff     <= seen_in;
         cur_kept_ff <= cur_kept_in;
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      pp_in       = pp_ff;
      column_in   = column_ff;
      tab_pend_in = tab_pend_ff;
      ffp_in      = ffp_ff;
      seen_in     = seen_ff;
      cur_kept_in = cur_kept_ff;
      fill        = '0;
      table_path  = 1'b0;
      p           = '0;

      if (map_take && 32'(column_ff) == 32'(in_column)) begin
         cur_kept_in = in_keep;
      end

      if (text_take) begin
         unique case (mode_ff)
            MODE_START: begin
               if (in_byte == CH_NL) begin
                  p = push_add(p, in_byte, '0);
               end else if (in_byte == CH_HASH) begin
                  p       = push_add(p, in_byte, '0);
                  mode_in = MODE_PREFIX;
                  pp_in   = PREFIX_W'(1);
               end else begin
                  mode_in    = MODE_TABLE;
                  pp_in      = '0;
                  table_path = 1'b1;
               end
            end
            MODE_PREFIX: begin
               p = push_add(p, in_byte, '0);
               if (in_byte == CH_NL) begin
                  mode_in = MODE_START;
                  pp_in   = '0;
               end else if (pp_ff < PREFIX_W'(HDR_LEN) && in_byte == hdr_char(pp_ff)) begin
                  pp_in = pp_ff + PREFIX_W'(1);
                  if (pp_in == PREFIX_W'(HDR_LEN)) begin
                     mode_in = MODE_TABLE;
                  end
               end else begin
                  mode_in = MODE_COMMENT;
               end
            end
            MODE_COMMENT: begin
               p = push_add(p, in_byte, '0);
               if (in_byte == CH_NL) begin
                  mode_in = MODE_START;
                  pp_in   = '0;
               end
            end
            MODE_TABLE: begin
               table_path = 1'b1;
            end
            default: begin
               mode_in = MODE_START;
            end
         endcase
      end

      if (table_path) begin
         if (in_byte == CH_NL) begin
            if (tab_pend_ff && !ffp_ff) begin
               p = push_add(p, CH_TAB, '0);
            end
            if (pp_ff != PREFIX_W'(HDR_LEN) && ffp_ff && eff_total > seen_ff) begin
               fill = FILL_W'(eff_total - seen_ff);
            end
            p           = push_add(p, CH_NL, fill);
            mode_in     = MODE_START;
            pp_in       = '0;
            column_in   = '0;
            tab_pend_in = 1'b0;
            ffp_in      = 1'b0;
            seen_in     = '0;
            cur_kept_in = 1'b0;
         end else begin
            if (tab_pend_ff) begin
               p           = push_add(p, CH_TAB, '0);
               tab_pend_in = 1'b0;
               if (column_ff >= CW'(FIXED_COLS - 1)) begin
                  ffp_in = 1'b1;
               end
               if (cur_kept_ff) begin
                  seen_in = seen_ff + CNT_W'(1);
               end
            end
            if (in_byte == CH_TAB) begin
               if (column_ff != COL_MAX) begin
                  column_in = column_ff + CW'(1);
               end
               cur_kept_in = nxt_kept_ff;
               tab_pend_in = (column_in < CW'(FIXED_COLS)) || nxt_kept_ff;
            end else if (column_ff < CW'(FIXED_COLS) || cur_kept_ff) begin
               p = push_add(p, in_byte, '0);
            end
         end
      end

      if (p.valid1) begin
         p.item1.last_of_run = 1'b1;
      end else if (p.valid0) begin
         p.item0.last_of_run = 1'b1;
      end
      push = p;
   end

endmodule

// ===== hw/rtl/tcss_fifo.sv =====
// Short result queue between front and back: two pushes, one pop per cycle.
// Depends on tcss_pkg.
module tcss_fifo import tcss_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  push_type        push,
   output logic            pop_valid,
   input  logic            pop_ready,
   output rsp_item_type    pop_item,
   output fifo_status_type status
);

   rsp_item_type          slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr_nx;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic [FIFO_CNT_W-1:0] n_push;
   logic                  pop;

   assign pop_valid = count_ff != '0;
   assign pop       = pop_valid && pop_ready;
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign n_push    = FIFO_CNT_W'(push.valid0) + FIFO_CNT_W'(push.valid1);
   assign wr_ptr_nx = wr_ptr_ff + FIFO_PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(n_push);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign count_in  = count_ff + n_push - FIFO_CNT_W'(pop);

   assign status.count  = count_ff;
   assign status.space2 = count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         slot_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.valid1) begin
         slot_ff[wr_ptr_nx] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/tcss_back.sv =====
// Back part: output register that drives results onto the result channel.
// Depends on tcss_pkg.
module tcss_back import tcss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         src_valid,
   output logic         src_ready,
   input  rsp_item_type src_item,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign src_ready = !valid_ff || out_ready;
   assign valid_in  = src_ready ? src_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (src_valid && src_ready) begin
         item_ff <= src_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== hw/rtl/tab_column_sample_select.sv =====
// Top level of the tab column sample select block: front, result queue, back.
// Depends on tcss_pkg, tcss_front, tcss_fifo, tcss_back and the macros header.
`include "tab_column_sample_select_macros.svh"

// Filters newline-terminated tab-separated text one byte per transfer. Comment and
// empty lines pass unchanged; on header and data lines columns 0 to 8 always pass
// and later columns pass only if their keep-map bit is set (op 1 writes one bit
// and yields no result). A newline of a data line with at least 9 fields carries
// in fill_before the count of tab-dot pairs to insert before it. The input takes
// one item per cycle; a byte that releases a held tab yields two results, and the
// result channel moves one per cycle, so a run of such bytes stalls the input to
// the output rate, set by the four-entry result queue and single output register.
// Each result is held in the result queue and then in the output register. After
// reset the keep map is swept clear, all MAX_COLUMNS entries, with req_tready low.
module tab_column_sample_select import tcss_pkg::*; #(
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [7:0] data_byte, [19:8] map_column, [20] map_keep, [23:21] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] op
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] out_byte, [20:8] fill_before, [23:21] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   push_type        push;
   fifo_status_type fifo_stat;
   logic            clearing;
   logic            fifo_valid, fifo_ready;
   rsp_item_type    fifo_item, out_item;

   tcss_front #(
      .MAX_COLUMNS(MAX_COLUMNS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (op_type'(req_tuser)),
      .in_byte   (req_tdata[7:0]),
      .in_column (req_tdata[19:8]),
      .in_keep   (req_tdata[20]),
      .fifo_stat (fifo_stat),
      .push      (push),
      .clearing  (clearing)
   );

   tcss_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_valid (fifo_valid),
      .pop_ready (fifo_ready),
      .pop_item  (fifo_item),
      .status    (fifo_stat)
   );

   tcss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .src_valid (fifo_valid),
      .src_ready (fifo_ready),
      .src_item  (fifo_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {3'b000, out_item.fill_before, out_item.out_byte};
   assign rsp_tlast = out_item.last_of_run;

   `TCSS_ASSERT_IMPLY(a_no_take_clearing, clock, reset, req_tvalid && req_tready, !clearing)
   `TCSS_ASSERT_IMPLY(a_fill_on_newline, clock, reset, rsp_tvalid && out_item.fill_before != '0, out_item.out_byte == CH_NL)
   `TCSS_ASSERT_IMPLY(a_push_order, clock, reset, push.valid1, push.valid0)
   `TCSS_ASSERT_IMPLY(a_fifo_bound, clock, reset, 1'b1, fifo_stat.count <= FIFO_CNT_W'(FIFO_DEPTH))
   `TCSS_ASSERT_NEXT(a_fifo_fill, clock, reset, push.valid0 && !(fifo_valid && fifo_ready), fifo_stat.count != '0)

endmodule

// ===== bench/tb_tab_column_sample_select.sv =====
// Self-checking testbench for tab_column_sample_select: streams text lines and keep-map writes,
// predicts every output byte in step with accepted transfers, and checks the result stream.
// Depends on tcss_pkg and the tab_column_sample_select RTL.
module tb_tab_column_sample_select;
   import tcss_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_COLS = 4096;
   localparam logic [47:0] HDR_TAG = "#CHROM";

   typedef struct packed {
      op_type                op;
      logic [BYTE_W-1:0]     data_byte;
      logic [MAPCOL_W-1:0]   map_column;
      logic                  map_keep;
   } filter_req_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   filter_req_type pending_req[$];
   rsp_item_type   expected_rsp[$];
   rsp_item_type   step_out[$];
   int             errors = 0;

   // filter state
   bit            keep_bits [0:MAX_COLS-1];
   int unsigned   keep_count;
   int unsigned   col_idx;
   line_mode_type line_mode;
   int unsigned   tag_pos;
   bit            tab_held;
   bit            has_format;
   int unsigned   kept_on_line;

   tab_column_sample_select #(.MAX_COLUMNS(MAX_COLS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] tag_char(input int unsigned p);
      return HDR_TAG[47 - 8 * p -: 8];
   endfunction

   function automatic bit col_kept(input int unsigned c);
      return c >= FIXED_COLS && c < MAX_COLS && keep_bits[c];
   endfunction

   function automatic bit col_passes(input int unsigned c);
      return c < FIXED_COLS || col_kept(c);
   endfunction

   function automatic void emit_byte(input logic [7:0] b, input int unsigned fill);
      rsp_item_type r;
      r.out_byte    = b;
      r.fill_before = fill[FILL_W-1:0];
      r.last_of_run = 1'b0;
      step_out.insert(step_out.size(), r);
   endfunction

   function automatic void clear_line();
      line_mode    = MODE_START;
      tag_pos      = 0;
      col_idx      = 0;
      tab_held     = 1'b0;
      has_format   = 1'b0;
      kept_on_line = 0;
   endfunction

   function automatic void release_tab();
      if (tab_held) begin
         tab_held = 1'b0;
         if (col_idx >= FIXED_COLS - 1)
            has_format = 1'b1;
         if (col_kept(col_idx))
            kept_on_line++;
         emit_byte(CH_TAB, 0);
      end
   endfunction

   function automatic void table_char(input logic [7:0] b);
      int unsigned fill;
      if (b == CH_NL) begin
         fill = 0;
         if (tab_held) begin
            if (has_format)
               tab_held = 1'b0;
            else
               emit_byte(CH_TAB, 0);
         end
         if (tag_pos != HDR_LEN && has_format)
            fill = (keep_count > kept_on_line) ? keep_count - kept_on_line : 0;
         emit_byte(CH_NL, fill);
         clear_line();
      end else begin
         release_tab();
         if (b == CH_TAB) begin
            if (col_idx < MAX_COLS)
               col_idx++;
            if (col_passes(col_idx))
               tab_held = 1'b1;
         end else if (col_passes(col_idx)) begin
            emit_byte(b, 0);
         end
      end
   endfunction

   function automatic void filter_step(input filter_req_type it);
      int unsigned c;
      logic [7:0]  b;
      b = it.data_byte;
      step_out.delete();
      if (it.op == OP_MAP) begin
         c = 32'(it.map_column);
         if (c >= FIXED_COLS && c < MAX_COLS && keep_bits[c] != it.map_keep) begin
            if (it.map_keep)
               keep_count++;
            else
               keep_count--;
            keep_bits[c] = it.map_keep;
         end
         return;
      end
      case (line_mode)
         MODE_START: begin
            if (b == CH_NL) begin
               emit_byte(b, 0);
            end else if (b == CH_HASH) begin
               emit_byte(b, 0);
               line_mode = MODE_PREFIX;
               tag_pos   = 1;
            end else begin
               line_mode = MODE_TABLE;
               tag_pos   = 0;
               table_char(b);
            end
         end
         MODE_PREFIX: begin
            emit_byte(b, 0);
            if (b == CH_NL) begin
               clear_line();
            end else if (tag_pos < HDR_LEN && b == tag_char(tag_pos)) begin
               tag_pos++;
               if (tag_pos == HDR_LEN)
                  line_mode = MODE_TABLE;
            end else begin
               line_mode = MODE_COMMENT;
            end
         end
         MODE_COMMENT: begin
            emit_byte(b, 0);
            if (b == CH_NL)
               clear_line();
         end
         default: table_char(b);
      endcase
      if (step_out.size() > 0)
         step_out[step_out.size() - 1].last_of_run = 1'b1;
      foreach (step_out[i])
         expected_rsp.insert(expected_rsp.size(), step_out[i]);
   endfunction

   // stimulus helpers
   function automatic logic [7:0] field_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CH_TAB || b == CH_NL);
      return b;
   endfunction

   task automatic put_char(input logic [7:0] b);
      filter_req_type r;
      r.op         = OP_TEXT;
      r.data_byte  = b;
      r.map_column = MAPCOL_W'($urandom_range(0, 4095));
      r.map_keep   = 1'($urandom_range(0, 1));
      pending_req.insert(pending_req.size(), r);
   endtask

   task automatic put_map(input int col, input bit keep);
      filter_req_type r;
      r.op         = OP_MAP;
      r.data_byte  = 8'($urandom_range(0, 255));
      r.map_column = MAPCOL_W'(col);
      r.map_keep   = keep;
      pending_req.insert(pending_req.size(), r);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         put_char(s[i]);
   endtask

   task automatic put_field(input int max_len);
      int n;
      n = $urandom_range(0, max_len);
      for (int i = 0; i < n; i++)
         put_char(field_byte());
   endtask

   task automatic put_random_map();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         put_map($urandom_range(9, 48), 1'($urandom_range(0, 1)));
      else if (r < 85)
         put_map($urandom_range(0, 8), 1'($urandom_range(0, 1)));
      else
         put_map($urandom_range(0, 4095), 1'($urandom_range(0, 1)));
   endtask

   task automatic put_table_line(input bit header, input int nfields, input bit trailing_tab);
      logic [7:0] b;
      for (int f = 0; f < nfields; f++) begin
         if (f > 0)
            put_char(CH_TAB);
         if ($urandom_range(0, 19) == 0)
            put_random_map();
         if (f == 0 && header) begin
            put_text("#CHROM");
            put_field(1);
         end else if (f == 0) begin
            if ($urandom_range(0, 5) != 0) begin
               do b = field_byte(); while (b == CH_HASH);
               put_char(b);
               put_field(3);
            end
         end else begin
            put_field(3);
         end
      end
      if (trailing_tab)
         put_char(CH_TAB);
      put_char(CH_NL);
   endtask

   function automatic int pick_fields();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2)
         return $urandom_range(1, 8);
      else if (r < 8)
         return $urandom_range(9, 24);
      return $urandom_range(25, 45);
   endfunction

   // driver
   int burst_left = 0;
   int gap_left = 0;
   filter_req_type drive_item;

   always @(posedge clock) begin : drive_proc
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            filter_step(drive_item);
         if (!req_tvalid || req_tready) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_req.size() > 0) begin
               drive_item = pending_req.pop_front();
               next_valid = 1'b1;
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                           : $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end
            req_tvalid <= next_valid;
            req_tdata  <= {3'b000, drive_item.map_keep, drive_item.map_column,
                           drive_item.data_byte};
            req_tuser  <= drive_item.op;
         end
      end
   end

   // receiver stall pattern: switch between four ready styles
   int stall_mode = 0;
   int stall_tick = 0;

   always @(posedge clock) begin : ready_proc
      logic next_ready;
      stall_tick++;
      if (stall_tick % 200 == 0)
         stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0:       next_ready = 1'b1;
         1:       next_ready = 1'($urandom_range(0, 1));
         2:       next_ready = (stall_tick % 4 == 0);
         default: next_ready = ($urandom_range(0, 3) != 0);
      endcase
      rsp_tready <= next_ready;
   end

   // monitor
   always @(posedge clock) begin : check_proc
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected transfer byte=%h fill=%0d last=%b", $time,
                     rsp_tdata[7:0], rsp_tdata[20:8], rsp_tlast);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_tdata[7:0] != want.out_byte || rsp_tdata[20:8] != want.fill_before ||
                rsp_tlast != want.last_of_run) begin
               errors++;
               $display("%0t: mismatch expected byte=%h fill=%0d last=%b", $time,
                        want.out_byte, want.fill_before, want.last_of_run);
               $display("%0t:          actual   byte=%h fill=%0d last=%b", $time,
                        rsp_tdata[7:0], rsp_tdata[20:8], rsp_tlast);
            end
         end
      end
   end

   initial begin
      #3_000_000;
      $display("** tab_column_sample_select: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int r;
      int n;
      int k;
      foreach (keep_bits[i])
         keep_bits[i] = 1'b0;
      keep_count = 0;
      clear_line();

      // directed
      put_map(5, 1'b1);
      put_map(9, 1'b1);
      put_map(11, 1'b1);
      put_map(4095, 1'b1);
      put_map(11, 1'b0);
      put_char(CH_NL);
      put_text("#x\n");
      put_text("a\tb\t\t\t\t\t\t\tc\t\td\n");

      // random lines
      while (pending_req.size() < 1640) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            put_table_line(1'b0, pick_fields(), $urandom_range(0, 5) == 0);
         end else if (r < 55) begin
            put_table_line(1'b1, pick_fields(), $urandom_range(0, 5) == 0);
         end else if (r < 65) begin
            k = $urandom_range(1, 5);
            for (int p = 0; p < k; p++)
               put_char(tag_char(p));
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++)
               put_char(($urandom_range(0, 3) == 0) ? CH_TAB : field_byte());
            put_char(CH_NL);
         end else if (r < 70) begin
            put_char(CH_NL);
         end else if (r < 85) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
               put_random_map();
         end else begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
               put_char(($urandom_range(0, 9) == 0) ? CH_NL : 8'($urandom_range(0, 255)));
            put_char(CH_NL);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_req.size() != 0 || req_tvalid)
         @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("** tab_column_sample_select: PASSED **");
      end else begin
         $display("** tab_column_sample_select: FAILED **");
      end
      $finish;
   end

endmodule

// ===== tab_column_sample_select.f =====
+incdir+hw/rtl
hw/rtl/tcss_pkg.sv
hw/rtl/tcss_front.sv
hw/rtl/tcss_fifo.sv
hw/rtl/tcss_back.sv
hw/rtl/tab_column_sample_select.sv
bench/tb_tab_column_sample_select.sv
